// File: rtl/core/pdc_pkg.sv
`default_nettype none
package pdc_pkg;

    localparam int LETTER_W = 5;
    localparam int SIDE = 5;
    localparam int SQUARE_W = SIDE * SIDE * LETTER_W;
    localparam int CFG_DATA_W = 50;
    localparam int CFG_INDEX_W = 3;
    localparam int PAIR_FIFO_DEPTH = 4;

    localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;

    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE         = 3'd0,
        CFG_SQUARE_UPPER = 3'd1,
        CFG_SQUARE_MID   = 3'd2,
        CFG_SQUARE_BOT   = 3'd3,
        CFG_FILLER       = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [LETTER_W-1:0] in_letter;
        logic                in_last;
    } pdc_in_t;

    typedef struct packed {
        logic [LETTER_W-1:0] out_letter;
        logic                out_last;
    } pdc_out_t;

    // one digraph on its way from the front to the back
    typedef struct packed {
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
        logic                last;
    } pdc_pair_t;

    function automatic logic [LETTER_W-1:0] fold(input logic [LETTER_W-1:0] v);
        fold = (v == LETTER_J) ? LETTER_I : v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/pdc_front.sv
`default_nettype none
module pdc_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              letter_valid,
    output logic                   letter_stall,
    input  wire pdc_pkg::pdc_in_t  letter,
    input  wire logic              mode,
    input  wire logic [4:0]        filler,
    output logic                   push_valid,
    output pdc_pkg::pdc_pair_t     push_data,
    input  wire logic              push_ready
);
    import pdc_pkg::*;

    logic [LETTER_W-1:0] held_reg, held_next;
    logic                held_valid_reg, held_valid_next;
    pdc_pair_t           pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                accept;
    logic [LETTER_W-1:0] lt;

    assign letter_stall = pend_valid_reg || !push_ready;
    assign accept = letter_valid && !letter_stall;
    assign lt = fold(letter.in_letter);

    always_comb
    begin
        held_next = held_reg;
        held_valid_next = held_valid_reg;
        pend_next = pend_reg;
        pend_valid_next = pend_valid_reg;
        push_valid = 1'b0;
        push_data = pend_reg;
        if (pend_valid_reg)
        begin
            push_valid = 1'b1;
            if (push_ready)
                pend_valid_next = 1'b0;
        end
        else if (accept)
        begin
            if (!held_valid_reg)
            begin
                if (letter.in_last)
                begin
                    push_valid = 1'b1;
                    push_data = '{first: lt, second: filler, last: 1'b1};
                end
                else
                begin
                    held_next = lt;
                    held_valid_next = 1'b1;
                end
            end
            else if (mode == MODE_ENCRYPT && lt == held_reg)
            begin
                // doubled letter: split with the filler, second letter starts a new pair
                push_valid = 1'b1;
                push_data = '{first: held_reg, second: filler, last: 1'b0};
                if (letter.in_last)
                begin
                    pend_next = '{first: lt, second: filler, last: 1'b1};
                    pend_valid_next = 1'b1;
                    held_valid_next = 1'b0;
                    held_next = '0;
                end
                else
                    held_next = lt;
            end
            else
            begin
                push_valid = 1'b1;
                push_data = '{first: held_reg, second: lt, last: letter.in_last};
                held_valid_next = 1'b0;
                held_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            held_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
            held_valid_reg <= held_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule
`default_nettype wire

// File: rtl/core/pdc_pair_fifo.sv
`default_nettype none
module pdc_pair_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push_valid,
    input  wire pdc_pkg::pdc_pair_t push_data,
    output logic                    push_ready,
    output logic                    head_valid,
    output pdc_pkg::pdc_pair_t      head_data,
    input  wire logic               pop
);
    import pdc_pkg::*;

    localparam int PTR_W = $clog2(PAIR_FIFO_DEPTH);
    localparam int CNT_W = $clog2(PAIR_FIFO_DEPTH + 1);

    pdc_pair_t          mem [PAIR_FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(PAIR_FIFO_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data = mem[rd_ptr_reg];
    assign do_push = push_valid && push_ready;
    assign do_pop = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

// File: rtl/core/pdc_back.sv
`default_nettype none
module pdc_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    head_valid,
    input  wire pdc_pkg::pdc_pair_t      head_data,
    output logic                         pop,
    input  wire logic                    mode,
    input  wire logic [pdc_pkg::SQUARE_W-1:0] square,
    output logic                         result_valid,
    input  wire logic                    result_stall,
    output pdc_pkg::pdc_out_t            result
);
    import pdc_pkg::*;

    // row in [5:3], column in [2:0]; first entry in raster order wins
    function automatic logic [5:0] locate(input logic [LETTER_W-1:0] v,
                                          input logic [SQUARE_W-1:0] sq);
        logic [5:0] pos;
        pos = '0;
        for (int r = SIDE - 1; r >= 0; r--)
        begin
            for (int c = SIDE - 1; c >= 0; c--)
            begin
                if (sq[(r * SIDE + c) * LETTER_W +: LETTER_W] == v)
                    pos = {3'(r), 3'(c)};
            end
        end
        locate = pos;
    endfunction

    function automatic logic [2:0] step_mod5(input logic [2:0] v, input logic dec);
        logic [3:0] s;
        s = {1'b0, v} + (dec ? 4'd4 : 4'd1);
        step_mod5 = (s >= 4'd5) ? 3'(s - 4'd5) : s[2:0];
    endfunction

    function automatic logic [LETTER_W-1:0] letter_at(input logic [2:0] r,
                                                      input logic [2:0] c,
                                                      input logic [SQUARE_W-1:0] sq);
        logic [6:0] base;
        base = (7'({r, 2'b00}) + 7'(r) + 7'(c)) * 7'd5;
        letter_at = sq[base +: LETTER_W];
    endfunction

    logic [5:0]          pa, pb;
    logic [2:0]          ra, ca, rb, cb, nra, nca, nrb, ncb;
    logic [LETTER_W-1:0] ea, eb;

    logic                pr_valid_reg, pr_valid_next;
    logic                pr_second_reg, pr_second_next;
    logic [LETTER_W-1:0] pr_a_reg, pr_a_next, pr_b_reg, pr_b_next;
    logic                pr_last_reg, pr_last_next;
    logic                out_valid_reg, out_valid_next;
    pdc_out_t            out_reg, out_next;
    logic                out_load, send, pr_free;

    always_comb
    begin
        pa = locate(fold(head_data.first), square);
        pb = locate(fold(head_data.second), square);
        ra = pa[5:3];
        ca = pa[2:0];
        rb = pb[5:3];
        cb = pb[2:0];
        if (ca == cb)
        begin
            nra = step_mod5(ra, mode);
            nrb = step_mod5(rb, mode);
            nca = ca;
            ncb = cb;
        end
        else if (ra == rb)
        begin
            nra = ra;
            nrb = rb;
            nca = step_mod5(ca, mode);
            ncb = step_mod5(cb, mode);
        end
        else
        begin
            nra = ra;
            nrb = rb;
            nca = cb;
            ncb = ca;
        end
        ea = letter_at(nra, nca, square);
        eb = letter_at(nrb, ncb, square);
    end

    assign out_load = !out_valid_reg || !result_stall;
    assign send = pr_valid_reg && out_load;
    assign pr_free = !pr_valid_reg || (send && pr_second_reg);
    assign pop = head_valid && pr_free;

    always_comb
    begin
        pr_valid_next = pr_valid_reg;
        pr_second_next = pr_second_reg;
        pr_a_next = pr_a_reg;
        pr_b_next = pr_b_reg;
        pr_last_next = pr_last_reg;
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        if (out_load)
        begin
            out_valid_next = send;
            out_next.out_letter = pr_second_reg ? pr_b_reg : pr_a_reg;
            out_next.out_last = pr_second_reg && pr_last_reg;
        end
        if (send)
            pr_second_next = 1'b1;
        if (pr_free)
        begin
            pr_valid_next = head_valid;
            pr_second_next = 1'b0;
            pr_a_next = ea;
            pr_b_next = eb;
            pr_last_next = head_data.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_valid_reg <= 1'b0;
            pr_second_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pr_valid_reg <= pr_valid_next;
            pr_second_reg <= pr_second_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pr_a_reg <= pr_a_next;
        pr_b_reg <= pr_b_next;
        pr_last_reg <= pr_last_next;
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result = out_reg;

endmodule
`default_nettype wire

// File: rtl/core/playfair_digraph_cipher.sv
`default_nettype none
// channel  | valid        | stall        | payload
// letters  | letter_valid | letter_stall | letter (pdc_in_t)
// results  | result_valid | result_stall | result (pdc_out_t)
// config   | cfg_write    | -            | cfg_index, cfg_data
//
// Results leave at one letter per cycle while not stalled, first letter then second.
// A letter request is taken every cycle while the pair queue has room and no pair is
// pending; an encrypt letter doubling the held one and ending the message leaves one.
// Key square lookup is combinational from the queue head into the pair register.
// Reset restores the default key square, encrypt mode and filler x; no clearing pass.
// Either side can stall independently; the four-deep pair queue decouples them.
module playfair_digraph_cipher (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             letter_valid,
    output logic                                  letter_stall,
    input  wire pdc_pkg::pdc_in_t                 letter,
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output pdc_pkg::pdc_out_t                     result,
    input  wire logic                             cfg_write,
    input  wire logic [pdc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [pdc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pdc_pkg::*;

    logic          mode_reg;
    logic [49:0]   sq_upper_reg;
    logic [49:0]   sq_mid_reg;
    logic [24:0]   sq_bot_reg;
    logic [4:0]    filler_reg;

    logic          push_valid, push_ready, head_valid, pop;
    pdc_pair_t     push_data, head_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ENCRYPT;
            sq_upper_reg <= 50'd107484862756300;
            sq_mid_reg <= 50'd688860520781988;
            sq_bot_reg <= 25'd26991284;
            filler_reg <= 5'd23;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MODE:         mode_reg <= cfg_data[0];
                CFG_SQUARE_UPPER: sq_upper_reg <= cfg_data[49:0];
                CFG_SQUARE_MID:   sq_mid_reg <= cfg_data[49:0];
                CFG_SQUARE_BOT:   sq_bot_reg <= cfg_data[24:0];
                CFG_FILLER:       filler_reg <= cfg_data[4:0];
                default:          ;
            endcase
        end
    end

    pdc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .letter_valid (letter_valid),
        .letter_stall (letter_stall),
        .letter       (letter),
        .mode         (mode_reg),
        .filler       (filler_reg),
        .push_valid   (push_valid),
        .push_data    (push_data),
        .push_ready   (push_ready)
    );

    pdc_pair_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop)
    );

    pdc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_data    (head_data),
        .pop          (pop),
        .mode         (mode_reg),
        .square       ({sq_bot_reg, sq_mid_reg, sq_upper_reg}),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
`default_nettype wire
